// ===== sv/psdl_pkg.sv =====
package psdl_pkg;

  // store geometry
  localparam int CAPACITY = 64;
  localparam int SLOT_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int COUNT_W  = $clog2(CAPACITY + 1);
  localparam int LINK_W   = 7;
  localparam int N_COORD  = 8;
  localparam int COORD_W  = 16;

  localparam logic [LINK_W-1:0] NULL_LINK = {LINK_W{1'b1}};

  localparam logic CMD_INSERT  = 1'b0;
  localparam logic CMD_DRAIN   = 1'b1;
  localparam logic KIND_QUAD   = 1'b0;
  localparam logic KIND_SHADOW = 1'b1;

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_DROPPED  = 2'd1,
    ST_DRAINED  = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef logic [N_COORD-1:0][COORD_W-1:0] coords_t;

  typedef struct packed {
    logic        command;
    logic        kind;
    logic [31:0] priority_req;
    logic [31:0] payload;
    coords_t     coord;
  } item_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] payload;
    coords_t     coord;
  } entry_t;

  typedef struct packed {
    status_t     status;
    logic        kind;
    logic [31:0] payload;
    coords_t     coord;
    logic        last;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic    take;
    logic    store;
    logic    head_only;
    logic    walk_start;
    logic    walk_step;
    logic    walk_hit;
    logic    walk_tail;
    logic    fix;
    logic    drn_start;
    logic    emit;
    logic    result;
    logic    clear;
    logic    set_code;
    status_t code;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_drain;
    logic full;
    logic empty_list;
    logic gt;
    logic link_null;
    logic last;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== sv/psdl_item_if.sv =====
interface psdl_item_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic               kind;
  logic signed [31:0] priority_req;
  logic        [31:0] payload;
  logic signed [15:0] x0;
  logic signed [15:0] y0;
  logic signed [15:0] x1;
  logic signed [15:0] y1;
  logic signed [15:0] x2;
  logic signed [15:0] y2;
  logic signed [15:0] x3;
  logic signed [15:0] y3;

  modport source (
    output valid, command, kind, priority_req, payload, x0, y0, x1, y1, x2, y2, x3, y3,
    input  ready
  );
  modport sink (
    input  valid, command, kind, priority_req, payload, x0, y0, x1, y1, x2, y2, x3, y3,
    output ready
  );
endinterface

// ===== sv/psdl_result_if.sv =====
interface psdl_result_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  status;
  logic               out_kind;
  logic        [31:0] out_payload;
  logic signed [15:0] out_x0;
  logic signed [15:0] out_y0;
  logic signed [15:0] out_x1;
  logic signed [15:0] out_y1;
  logic signed [15:0] out_x2;
  logic signed [15:0] out_y2;
  logic signed [15:0] out_x3;
  logic signed [15:0] out_y3;
  logic               last;

  modport source (
    output valid, status, out_kind, out_payload, out_x0, out_y0, out_x1, out_y1,
           out_x2, out_y2, out_x3, out_y3, last,
    input  ready
  );
  modport sink (
    input  valid, status, out_kind, out_payload, out_x0, out_y0, out_x1, out_y1,
           out_x2, out_y2, out_x3, out_y3, last,
    output ready
  );
endinterface

// ===== sv/psdl_ctrl.sv =====
module psdl_ctrl
  import psdl_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECODE = 6'b000010,
    S_WALK   = 6'b000100,
    S_FIX    = 6'b001000,
    S_RESULT = 6'b010000,
    S_EMIT   = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.code   = ST_ACCEPTED;
    in_ready   = 1'b0;
    state_next = state;
    case (state)
      S_IDLE: begin
        // no transfer while reset is held
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.take   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.is_drain) begin
          if (stat.empty_list) begin
            cmd.set_code = 1'b1;
            cmd.code     = ST_EMPTY;
            cmd.clear    = 1'b1;
            state_next   = S_RESULT;
          end else begin
            cmd.drn_start = 1'b1;
            state_next    = S_EMIT;
          end
        end else if (stat.full) begin
          cmd.set_code = 1'b1;
          cmd.code     = ST_DROPPED;
          state_next   = S_RESULT;
        end else begin
          cmd.store    = 1'b1;
          cmd.set_code = 1'b1;
          cmd.code     = ST_ACCEPTED;
          if (stat.empty_list) begin
            cmd.head_only = 1'b1;
            state_next    = S_RESULT;
          end else begin
            cmd.walk_start = 1'b1;
            state_next     = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (stat.gt) begin
          cmd.walk_hit = 1'b1;
          state_next   = S_FIX;
        end else if (stat.link_null) begin
          cmd.walk_tail = 1'b1;
          state_next    = S_FIX;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      S_FIX: begin
        cmd.fix    = 1'b1;
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (stat.out_free) begin
          cmd.result = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.last) begin
            cmd.clear  = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/psdl_dp.sv =====
module psdl_dp
  import psdl_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  dp_cmd_t  cmd,
  output dp_stat_t stat,
  input  item_t    in_item,
  output logic     out_valid,
  input  logic     out_ready,
  output result_t  res
);

  // entry stores
  logic [LINK_W-1:0] link_mem [CAPACITY];
  logic [31:0]       pri_mem  [CAPACITY];
  entry_t            ent_mem  [CAPACITY];

  logic [LINK_W-1:0] link_rd;
  logic [31:0]       pri_rd;
  entry_t            ent_rd;

  item_t             item;
  logic [LINK_W-1:0] head;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] rem;
  logic [SLOT_W-1:0] cur;
  logic [LINK_W-1:0] prev;
  logic [LINK_W-1:0] fix_tgt;
  status_t           code;

  logic [SLOT_W-1:0] slot;
  logic [SLOT_W-1:0] rd_addr;
  logic              link_we;
  logic [SLOT_W-1:0] link_wa;
  logic [LINK_W-1:0] link_wd;
  logic              fix_null;
  entry_t            ent_wd;

  assign slot     = count[SLOT_W-1:0];
  assign fix_null = (fix_tgt == NULL_LINK);

  always_comb begin
    if (cmd.walk_start || cmd.drn_start) begin
      rd_addr = head[SLOT_W-1:0];
    end else if (cmd.walk_step || cmd.emit) begin
      rd_addr = link_rd[SLOT_W-1:0];
    end else begin
      rd_addr = cur;
    end
  end

  always_comb begin
    link_we = cmd.head_only || cmd.walk_hit || cmd.walk_tail || (cmd.fix && !fix_null);
    link_wa = cmd.fix ? fix_tgt[SLOT_W-1:0] : slot;
    if (cmd.fix) begin
      link_wd = LINK_W'(slot);
    end else if (cmd.walk_hit) begin
      link_wd = LINK_W'(cur);
    end else begin
      link_wd = NULL_LINK;
    end
  end

  // shadows keep only the first coordinate
  always_comb begin
    ent_wd.kind    = item.kind;
    ent_wd.payload = item.payload;
    for (int j = 0; j < N_COORD; j++) begin
      ent_wd.coord[j] = (item.kind == KIND_SHADOW && j != 0) ? '0 : item.coord[j];
    end
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    if (cmd.store) begin
      pri_mem[slot] <= item.priority_req;
      ent_mem[slot] <= ent_wd;
    end
  end

  always_ff @(posedge clk) begin
    link_rd <= link_mem[rd_addr];
    pri_rd  <= pri_mem[rd_addr];
    ent_rd  <= ent_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= NULL_LINK;
      count <= '0;
    end else if (cmd.clear) begin
      head  <= NULL_LINK;
      count <= '0;
    end else begin
      if (cmd.head_only || (cmd.fix && fix_null)) begin
        head <= LINK_W'(slot);
      end
      if (cmd.head_only || cmd.fix) begin
        count <= count + COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      item <= in_item;
    end
    if (cmd.set_code) begin
      code <= cmd.code;
    end
    if (cmd.walk_start || cmd.drn_start) begin
      cur <= head[SLOT_W-1:0];
    end else if (cmd.walk_step || cmd.emit) begin
      cur <= link_rd[SLOT_W-1:0];
    end
    if (cmd.walk_start) begin
      prev <= NULL_LINK;
    end else if (cmd.walk_step) begin
      prev <= LINK_W'(cur);
    end
    if (cmd.walk_hit) begin
      fix_tgt <= prev;
    end else if (cmd.walk_tail) begin
      fix_tgt <= LINK_W'(cur);
    end
    if (cmd.drn_start) begin
      rem <= count;
    end else if (cmd.emit) begin
      rem <= rem - COUNT_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.result || cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result) begin
      res.status  <= code;
      res.kind    <= 1'b0;
      res.payload <= '0;
      res.coord   <= '0;
      res.last    <= 1'b1;
    end else if (cmd.emit) begin
      res.status  <= ST_DRAINED;
      res.kind    <= ent_rd.kind;
      res.payload <= ent_rd.payload;
      res.coord   <= ent_rd.coord;
      res.last    <= stat.last;
    end
  end

  always_comb begin
    stat.is_drain   = (item.command == CMD_DRAIN);
    stat.full       = (count == COUNT_W'(CAPACITY));
    stat.empty_list = (head == NULL_LINK) || (count == '0);
    stat.gt         = ($signed(item.priority_req) > $signed(pri_rd));
    stat.link_null  = (link_rd == NULL_LINK);
    stat.last       = (rem == COUNT_W'(1));
    stat.out_free   = !out_valid || out_ready;
  end

`ifndef ASSERT_OFF
  a_head_count: assert property (@(posedge clk) disable iff (rst)
    (head == NULL_LINK) == (count == '0))
    else $error("head and count disagree on empty list");

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.result || cmd.emit) |-> (!out_valid || out_ready))
    else $error("output register loaded while held");

  a_drain_end: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && stat.last) |=> (count == '0 && out_valid && res.last))
    else $error("final drained entry did not empty the list");
`endif

endmodule

// ===== sv/priority_sorted_display_list.sv =====
// channel   dir   transfer carries
// items     in    command, kind, priority_req, payload, x0..y3
// results   out   status, out_kind, out_payload, out_x0..out_y3, last
//
// insert: decode, a walk over k entries (k up to the list length), link fixup,
//   result; one entry per cycle set by the single read port of the stores
// drain: decode, then one result per cycle while results.ready stays high
// rst is synchronous: list empty at once, no clearing pass over the stores
// a held result blocks only the next load; a new item is taken meanwhile
module priority_sorted_display_list
  import psdl_pkg::*;
(
  input logic           clk,
  input logic           rst,
  psdl_item_if.sink     items,
  psdl_result_if.source results
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  item_t    in_item;
  result_t  res;

  // fields of an item, coordinates in x0, y0 .. x3, y3 order
  assign in_item.command      = items.command;
  assign in_item.kind         = items.kind;
  assign in_item.priority_req = items.priority_req;
  assign in_item.payload      = items.payload;
  assign in_item.coord[0]     = items.x0;
  assign in_item.coord[1]     = items.y0;
  assign in_item.coord[2]     = items.x1;
  assign in_item.coord[3]     = items.y1;
  assign in_item.coord[4]     = items.x2;
  assign in_item.coord[5]     = items.y2;
  assign in_item.coord[6]     = items.x3;
  assign in_item.coord[7]     = items.y3;

  // sequencer: decode, list walk, link fixup, drain
  psdl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .in_ready (items.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // stores, list pointers and output register
  psdl_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_item   (in_item),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .res       (res)
  );

  assign results.status      = res.status;
  assign results.out_kind    = res.kind;
  assign results.out_payload = res.payload;
  assign results.out_x0      = res.coord[0];
  assign results.out_y0      = res.coord[1];
  assign results.out_x1      = res.coord[2];
  assign results.out_y1      = res.coord[3];
  assign results.out_x2      = res.coord[4];
  assign results.out_y2      = res.coord[5];
  assign results.out_x3      = res.coord[6];
  assign results.out_y3      = res.coord[7];
  assign results.last        = res.last;

endmodule
